FILE: rtl/lorentzian_window_weight_defines.svh
// assertion macros, clocked on clk and disabled while rst_n is low
`ifndef LORENTZIAN_WINDOW_WEIGHT_DEFINES_SVH
`define LORENTZIAN_WINDOW_WEIGHT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LWW_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lww same-cycle check failed");
`define LWW_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lww next-cycle check failed");
`else
`define LWW_ASSERT_IMPL(label, a, b)
`define LWW_ASSERT_NEXT(label, a, b)
`endif

`endif

FILE: rtl/lww_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lww_pkg;

    localparam int DATA_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int QUOT_W      = 17;
    localparam int STEP_CNT_W  = 5;

    localparam logic [DATA_W-1:0]     ONE_Q16       = 32'h0001_0000;
    localparam logic [DATA_W-1:0]     MAX_U32       = 32'hFFFF_FFFF;
    localparam logic [STEP_CNT_W-1:0] DIV_LAST_STEP = 5'd16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EVAL_TIME    = 2'd0,
        REG_WINDOW_START = 2'd1,
        REG_WINDOW_END   = 2'd2,
        REG_INV_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic abs_d;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic acc;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/lww_key_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lww_key_if;
    logic                               valid;
    logic                               ready;
    logic signed [lww_pkg::DATA_W-1:0]  key_time;
    logic                               last;

    modport source (output valid, output key_time, output last, input ready);
    modport sink (input valid, input key_time, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/lww_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lww_result_if;
    logic                        valid;
    logic                        ready;
    logic [lww_pkg::DATA_W-1:0]  weight;
    logic                        saturated;

    modport source (output valid, output weight, output saturated, input ready);
    modport sink (input valid, input weight, input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/lww_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lww_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire lww_pkg::sts_t sts,
    output lww_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_MUL1,
        S_MUL2,
        S_DIV_INIT,
        S_DIV,
        S_ACC
    } state_t;

    state_t                            state_reg, state_next;
    logic [lww_pkg::STEP_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              can_finish;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign can_finish = !sts.last || !out_valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                cmd.abs_d  = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = sts.hit ? S_MUL2 : S_ACC;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + {{(lww_pkg::STEP_CNT_W-1){1'b0}}, 1'b1};
                if (cnt_reg == lww_pkg::DIV_LAST_STEP)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc = can_finish;
                if (can_finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.acc && sts.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lww_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lww_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lww_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [lww_pkg::DATA_W-1:0]          cfg_data,
    input  wire logic signed [lww_pkg::DATA_W-1:0]   key_time,
    input  wire logic                                last,
    input  wire lww_pkg::cmd_t                       cmd,
    output lww_pkg::sts_t                            sts,
    output logic [lww_pkg::DATA_W-1:0]               weight,
    output logic                                     saturated
);

    localparam int W = lww_pkg::DATA_W;

    // configuration
    logic signed [W-1:0] eval_time_reg, window_start_reg, window_end_reg;
    logic [W-1:0]        inv_radius_reg;

    // per-item pipeline of the term
    logic                hit_reg, last_reg;
    logic [W:0]          d_reg;
    logic [W-1:0]        ad_reg;
    logic [47:0]         z_reg;
    logic [W-1:0]        zsq_reg;
    logic                zsat_reg;
    logic [W:0]          denom_reg;
    logic [W:0]          rem_reg;
    logic [lww_pkg::QUOT_W-1:0] quot_reg;

    // running state and result
    logic [W-1:0]        weight_sum_reg, weight_sum_next;
    logic                sat_seen_reg, sat_seen_next;
    logic [W-1:0]        weight_reg;
    logic                saturated_reg;

    logic                in_window;
    logic [W:0]          d_next;
    logic [2*W-1:0]      prod1, prod2;
    logic [W+1:0]        shifted;
    logic                ge;
    logic [W:0]          sum;
    logic                add_sat;

    assign sts.hit   = hit_reg;
    assign sts.last  = last_reg;
    assign weight    = weight_reg;
    assign saturated = saturated_reg;

    assign in_window = (key_time >= window_start_reg) && (key_time <= window_end_reg);
    assign d_next    = {eval_time_reg[W-1], eval_time_reg} - {key_time[W-1], key_time};
    assign prod1     = {{W{1'b0}}, ad_reg} * {{W{1'b0}}, inv_radius_reg};
    assign prod2     = {{W{1'b0}}, z_reg[W-1:0]} * {{W{1'b0}}, z_reg[W-1:0]};
    assign shifted   = {rem_reg, 1'b0};
    assign ge        = shifted >= {1'b0, denom_reg};
    assign sum       = {1'b0, weight_sum_reg} + {{(W+1-lww_pkg::QUOT_W){1'b0}}, quot_reg};
    assign add_sat   = sum[W] || zsat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_time_reg    <= '0;
            window_start_reg <= '0;
            window_end_reg   <= lww_pkg::ONE_Q16;
            inv_radius_reg   <= lww_pkg::ONE_Q16;
        end
        else if (cfg_we)
        begin
            unique case (lww_pkg::cfg_reg_t'(cfg_index))
                lww_pkg::REG_EVAL_TIME:    eval_time_reg    <= cfg_data;
                lww_pkg::REG_WINDOW_START: window_start_reg <= cfg_data;
                lww_pkg::REG_WINDOW_END:   window_end_reg   <= cfg_data;
                lww_pkg::REG_INV_RADIUS:   inv_radius_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hit_reg  <= in_window;
            last_reg <= last;
            d_reg    <= d_next;
        end
        if (cmd.abs_d)
        begin
            ad_reg <= d_reg[W] ? W'(~d_reg + (W+1)'(1)) : d_reg[W-1:0];
        end
        if (cmd.mul1)
        begin
            z_reg <= prod1[2*W-1:16];
        end
        if (cmd.mul2)
        begin
            if ((|z_reg[47:W]) || (|prod2[2*W-1:48]))
            begin
                zsq_reg  <= lww_pkg::MAX_U32;
                zsat_reg <= 1'b1;
            end
            else
            begin
                zsq_reg  <= prod2[47:16];
                zsat_reg <= 1'b0;
            end
        end
        if (cmd.div_init)
        begin
            denom_reg <= {1'b0, zsq_reg} + {1'b0, lww_pkg::ONE_Q16};
            rem_reg   <= (W+1)'(1) << 15;
            quot_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? (W+1)'(shifted - {1'b0, denom_reg}) : shifted[W:0];
            quot_reg <= {quot_reg[lww_pkg::QUOT_W-2:0], ge};
        end
        if (cmd.acc && last_reg)
        begin
            weight_reg    <= weight_sum_next;
            saturated_reg <= sat_seen_next;
        end
    end

    always_comb
    begin
        weight_sum_next = weight_sum_reg;
        sat_seen_next   = sat_seen_reg;
        if (hit_reg)
        begin
            weight_sum_next = sum[W] ? lww_pkg::MAX_U32 : sum[W-1:0];
            sat_seen_next   = sat_seen_reg || add_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_sum_reg <= '0;
            sat_seen_reg   <= 1'b0;
        end
        else if (cmd.acc)
        begin
            weight_sum_reg <= last_reg ? '0 : weight_sum_next;
            sat_seen_reg   <= last_reg ? 1'b0 : sat_seen_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lorentzian_window_weight.sv
// channel     | dir | payload                   | request
// key_stream  | in  | key_time (s32), last (1)  | one key time
// result      | out | weight (u32), saturated   | one sum, on each last key time
// cfg         | in  | cfg_index (2), cfg_data   | one register write, no stall
//
// key time inside the window: ready returns after the 17-step restoring divider
// that forms 1/(1+z^2); outside the window the divider is skipped
// reset loads the register defaults and clears the sum; no clearing pass
// a last key time waits in its final step while the previous result is untaken
`timescale 1ns / 1ps
`default_nettype none
`include "lorentzian_window_weight_defines.svh"

module lorentzian_window_weight (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    lww_key_if.sink                               key_stream,
    lww_result_if.source                          result,
    input  wire logic                             cfg_we,
    input  wire logic [lww_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lww_pkg::DATA_W-1:0]       cfg_data
);

    lww_pkg::cmd_t cmd;
    lww_pkg::sts_t sts;

    lww_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (key_stream.valid),
        .in_ready  (key_stream.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lww_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_time  (key_stream.key_time),
        .last      (key_stream.last),
        .cmd       (cmd),
        .sts       (sts),
        .weight    (result.weight),
        .saturated (result.saturated)
    );

    `LWW_ASSERT_NEXT(a_busy_after_accept, key_stream.valid && key_stream.ready, !key_stream.ready)
    `LWW_ASSERT_NEXT(a_last_gives_result, cmd.acc && sts.last, result.valid)
    `LWW_ASSERT_IMPL(a_one_command, 1'b1, $onehot0(cmd))
    `LWW_ASSERT_IMPL(a_div_not_ready, cmd.div_step, !key_stream.ready)

endmodule

`default_nettype wire

FILE: sim/tb_lorentzian_window_weight.sv
`timescale 1ns / 1ps

module tb_lorentzian_window_weight;

    localparam int DATA_W = lww_pkg::DATA_W;
    localparam logic [DATA_W-1:0] ONE_Q16 = lww_pkg::ONE_Q16;
    localparam logic [DATA_W-1:0] MAX_U32 = lww_pkg::MAX_U32;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned QUIET_CYCLES = 32;
    localparam int unsigned MAX_REPORTS = 100;
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_KEYS = 250;

    typedef struct packed {
        logic [DATA_W-1:0] weight;
        logic              saturated;
    } weight_result_t;

    class weight_scoreboard;
        logic [DATA_W-1:0] t_eval;
        logic [DATA_W-1:0] win_lo;
        logic [DATA_W-1:0] win_hi;
        logic [DATA_W-1:0] inv_r;
        logic [DATA_W-1:0] acc_weight;
        logic              acc_sat;
        weight_result_t    expected_q[$];
        int unsigned       fail_count;

        function new();
            t_eval = '0;
            win_lo = '0;
            win_hi = ONE_Q16;
            inv_r = ONE_Q16;
            acc_weight = '0;
            acc_sat = 1'b0;
            fail_count = 0;
        endfunction

        function void write_reg(lww_pkg::cfg_reg_t idx, logic [DATA_W-1:0] v);
            case (idx)
                lww_pkg::REG_EVAL_TIME:    t_eval = v;
                lww_pkg::REG_WINDOW_START: win_lo = v;
                lww_pkg::REG_WINDOW_END:   win_hi = v;
                lww_pkg::REG_INV_RADIUS:   inv_r = v;
                default:                   ;
            endcase
        endfunction

        // 1/(1+z^2) in q16.16, z = |eval - key| * inv_r
        function logic [DATA_W-1:0] cauchy_term(logic [DATA_W-1:0] key, output logic sat);
            logic signed [33:0] diff;
            logic [33:0]        absd;
            logic [63:0]        zval;
            logic [63:0]        zsq;
            logic [63:0]        denom;
            sat = 1'b0;
            diff = $signed({{2{t_eval[31]}}, t_eval}) - $signed({{2{key[31]}}, key});
            absd = diff[33] ? -diff : diff;
            zval = ({30'b0, absd} * {32'b0, inv_r}) >> 16;
            if (zval > 64'h0000_0000_FFFF_FFFF)
            begin
                zsq = {32'b0, MAX_U32};
                sat = 1'b1;
            end
            else
            begin
                zsq = (zval * zval) >> 16;
                if (zsq > 64'h0000_0000_FFFF_FFFF)
                begin
                    zsq = {32'b0, MAX_U32};
                    sat = 1'b1;
                end
            end
            denom = zsq + {32'b0, ONE_Q16};
            return 32'((64'd1 << 32) / denom);
        endfunction

        function void note_key(logic [DATA_W-1:0] key, logic last);
            logic [DATA_W-1:0] term;
            logic [DATA_W:0]   sum;
            logic              sat;
            if ($signed(key) >= $signed(win_lo) && $signed(key) <= $signed(win_hi))
            begin
                term = cauchy_term(key, sat);
                sum = {1'b0, acc_weight} + {1'b0, term};
                if (sum[DATA_W])
                begin
                    acc_weight = MAX_U32;
                    sat = 1'b1;
                end
                else
                begin
                    acc_weight = sum[DATA_W-1:0];
                end
                if (sat)
                    acc_sat = 1'b1;
            end
            if (last)
            begin
                expected_q.push_back('{weight: acc_weight, saturated: acc_sat});
                acc_weight = '0;
                acc_sat = 1'b0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            if (fail_count < MAX_REPORTS)
                $display("[%0t] check failed: %s", $time, msg);
            fail_count++;
        endtask

        task check_result(logic [DATA_W-1:0] w, logic s);
            weight_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with none pending, weight=%h saturated=%b", w, s));
                return;
            end
            exp_r = expected_q.pop_front();
            if (w !== exp_r.weight)
                report($sformatf("weight %h, predicted %h", w, exp_r.weight));
            if (s !== exp_r.saturated)
                report($sformatf("saturated %b, predicted %b", s, exp_r.saturated));
        endtask

        task drain_check();
            while (expected_q.size() != 0)
            begin
                report($sformatf("result never came, weight=%h", expected_q[0].weight));
                void'(expected_q.pop_front());
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    lww_pkg::cfg_reg_t cfg_index;
    logic [DATA_W-1:0] cfg_data;
    bit                idle_on;
    int unsigned       cycles = 0;
    weight_scoreboard  sb;

    lww_key_if    key_if();
    lww_result_if res_if();

    lorentzian_window_weight dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_stream (key_if),
        .result     (res_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: take requests, stall in bursts while idle_on is set
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                sb.check_result(res_if.weight, res_if.saturated);
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_key(logic [DATA_W-1:0] k, logic l);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            key_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        key_if.valid <= 1'b1;
        key_if.key_time <= k;
        key_if.last <= l;
        do @(posedge clk); while (!key_if.ready);
        sb.note_key(k, l);
    endtask

    task automatic settle();
        key_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(lww_pkg::cfg_reg_t idx, logic [DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task automatic load_regs(logic [DATA_W-1:0] ev, logic [DATA_W-1:0] st,
                             logic [DATA_W-1:0] en, logic [DATA_W-1:0] ir);
        write_reg(lww_pkg::REG_EVAL_TIME, ev);
        write_reg(lww_pkg::REG_WINDOW_START, st);
        write_reg(lww_pkg::REG_WINDOW_END, en);
        write_reg(lww_pkg::REG_INV_RADIUS, ir);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_key(logic [DATA_W-1:0] ev,
                                                    logic [DATA_W-1:0] st,
                                                    logic [DATA_W-1:0] en);
        longint lo;
        longint hi;
        longint k;
        int unsigned sel;
        lo = longint'($signed(st));
        hi = longint'($signed(en));
        sel = $urandom_range(0, 9);
        if (sel < 4 && lo <= hi)
            k = lo + longint'({32'b0, $urandom}) % (hi - lo + 1);
        else if (sel < 7)
            k = longint'($signed(ev)) + longint'($urandom_range(0, 32'h0004_0000)) - 64'sh2_0000;
        else if (sel < 8)
        begin
            case ($urandom_range(0, 3))
                0:       k = lo - 1;
                1:       k = lo;
                2:       k = hi;
                default: k = hi + 1;
            endcase
        end
        else
            k = longint'($signed($urandom));
        if (k > 64'sh7FFF_FFFF)
            k = 64'sh7FFF_FFFF;
        if (k < -64'sh8000_0000)
            k = -64'sh8000_0000;
        return k[DATA_W-1:0];
    endfunction

    initial
    begin
        logic [DATA_W-1:0] ev;
        logic [DATA_W-1:0] st;
        logic [DATA_W-1:0] en;
        logic [DATA_W-1:0] ir;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              lst;
        int unsigned p;
        int unsigned i;

        sb = new();
        idle_on = 1'b1;
        rst_n = 1'b0;
        key_if.valid = 1'b0;
        key_if.key_time = '0;
        key_if.last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lww_pkg::REG_EVAL_TIME;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window [0, 1.0], eval 0, radius 1.0
        send_key(32'h0000_0000, 1'b1);
        send_key(ONE_Q16, 1'b0);
        send_key(32'h0000_8000, 1'b1);
        send_key(32'hFFFF_FFFF, 1'b1);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b1);
        settle();

        // full window, widest distance, largest inverse radius
        load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h7FFF_0000, 1'b1);
        settle();

        // zero inverse radius: every term is one
        load_regs(32'h0001_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b1);
        settle();

        // saturation flagged, then the list ends in an empty window
        load_regs(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_key(32'h4000_0000, 1'b0);
        settle();
        load_regs(32'h0000_0000, ONE_Q16, 32'h0000_0000, ONE_Q16);
        send_key(32'h0000_8000, 1'b1);
        send_key(32'h0000_0000, 1'b1);
        settle();

        // single-point window
        load_regs(32'h0000_0000, ONE_Q16, ONE_Q16, ONE_Q16);
        send_key(ONE_Q16, 1'b0);
        send_key(ONE_Q16 + 32'd1, 1'b0);
        send_key(ONE_Q16 - 32'd1, 1'b1);
        settle();

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            idle_on = (p != PHASE_COUNT - 1);
            a = $urandom;
            b = $urandom;
            if ($signed(a) > $signed(b))
            begin
                st = b;
                en = a;
            end
            else
            begin
                st = a;
                en = b;
            end
            case (p % 4)
                0:
                begin
                    ev = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    st = 32'h8000_0000;
                    en = 32'h7FFF_FFFF;
                    ir = (p == 0) ? 32'hFFFF_FFFF : $urandom;
                end
                1:
                begin
                    ev = $urandom;
                    ir = $urandom >> $urandom_range(0, 31);
                end
                2:
                begin
                    ev = $urandom;
                    if (p == 2)
                        ir = 32'h0000_0000;
                    else
                    begin
                        // empty window
                        ir = $urandom >> $urandom_range(0, 31);
                        a = st;
                        st = en + 32'd1;
                        en = a;
                    end
                end
                default:
                begin
                    ev = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
                    st = ev - $urandom_range(0, 32'h0040_0000);
                    en = ev + $urandom_range(0, 32'h0040_0000);
                    ir = $urandom_range(32'h0000_4000, 32'h0004_0000);
                end
            endcase
            load_regs(ev, st, en, ir);
            for (i = 0; i < PHASE_KEYS; i++)
            begin
                if (p == PHASE_COUNT - 1 && i == PHASE_KEYS - 1)
                    lst = 1'b1;
                else
                    lst = ($urandom_range(0, 3) == 0);
                send_key(pick_key(ev, st, en), lst);
            end
            settle();
        end

        sb.drain_check();
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: lorentzian_window_weight.f
+incdir+rtl
rtl/lww_pkg.sv
rtl/lww_key_if.sv
rtl/lww_result_if.sv
rtl/lww_ctrl.sv
rtl/lww_datapath.sv
rtl/lorentzian_window_weight.sv
sim/tb_lorentzian_window_weight.sv
